// ----- rtl/jqqs_pkg.sv -----
// Package for the JPEG quality quantizer scaler.
// Holds the quality-to-scale mapping and the reciprocal lookup tables.
// No dependencies.
`default_nettype none

package jqqs_pkg;

  localparam int unsigned BaseW  = 8;
  localparam int unsigned QualW  = 7;
  localparam int unsigned ScaleW = 13;
  localparam int unsigned ProdW  = 21;
  localparam int unsigned QuantW = 8;
  localparam int unsigned RecipW = 16;
  localparam int unsigned DcW    = 11;
  localparam int unsigned SramW  = 23;
  localparam int unsigned OutW   = 48;

  localparam logic [ProdW-1:0]  ROUND_BIAS  = ProdW'(50);
  localparam logic [ProdW-1:0]  SAT_LIMIT   = ProdW'(25600);
  localparam logic [ScaleW-1:0] DIV100_MULT = ScaleW'(5243);
  localparam logic [QualW-1:0]  QUAL_MIN    = QualW'(1);
  localparam logic [QualW-1:0]  QUAL_MAX    = QualW'(100);
  localparam logic [QualW-1:0]  QUAL_KNEE   = QualW'(50);
  localparam logic [ScaleW-1:0] SCALE_RESET = ScaleW'(20);

  typedef logic [49:0][ScaleW-1:0] scale_lut_t;
  typedef logic [255:0][RecipW-1:0] recip_lut_t;
  typedef logic [255:0][DcW-1:0] dc_lut_t;

  // 5000 / quality for quality 1..49; entry 0 is unused, as quality is clamped to 1 first.
  localparam scale_lut_t SCALE_LOW = {
    13'd102, 13'd104, 13'd106, 13'd108, 13'd111, 13'd113, 13'd116, 13'd119, 13'd121,
    13'd125, 13'd128, 13'd131, 13'd135, 13'd138, 13'd142, 13'd147, 13'd151, 13'd156,
    13'd161, 13'd166, 13'd172, 13'd178, 13'd185, 13'd192, 13'd200, 13'd208, 13'd217,
    13'd227, 13'd238, 13'd250, 13'd263, 13'd277, 13'd294, 13'd312, 13'd333, 13'd357,
    13'd384, 13'd416, 13'd454, 13'd500, 13'd555, 13'd625, 13'd714, 13'd833, 13'd1000,
    13'd1250, 13'd1666, 13'd2500, 13'd5000, 13'd5000
  };

  function automatic logic [ScaleW-1:0] scale_of(input logic [QualW-1:0] qual);
    logic [QualW-1:0] qc;
    qc = qual;
    if (qc < QUAL_MIN) qc = QUAL_MIN;
    if (qc > QUAL_MAX) qc = QUAL_MAX;
    if (qc < QUAL_KNEE) begin
      scale_of = SCALE_LOW[qc[5:0]];
    end else begin
      scale_of = ScaleW'(200) - {{(ScaleW-QualW-1){1'b0}}, qc, 1'b0};
    end
  endfunction

  // Shift-and-subtract quotient for building the tables at elaboration.
  function automatic int unsigned div_floor(input int unsigned num,
                                            input int unsigned den);
    int unsigned quo;
    int unsigned rem;
    int          b;
    quo = 0;
    rem = 0;
    for (b = 31; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 32'd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (32'd1 << b);
      end
    end
    return quo;
  endfunction

  // 65536 / q + 1, saturated to 16 bits.
  function automatic recip_lut_t build_recip();
    recip_lut_t  t;
    int unsigned r;
    int          i;
    t[0] = '1;
    for (i = 1; i < 256; i++) begin
      r = div_floor(65536, i) + 1;
      if (r > 65535) r = 65535;
      t[i] = RecipW'(r);
    end
    return t;
  endfunction

  // 1024 / q, truncated.
  function automatic dc_lut_t build_dc();
    dc_lut_t t;
    int      i;
    t[0] = '0;
    for (i = 1; i < 256; i++) begin
      t[i] = DcW'(div_floor(1024, i));
    end
    return t;
  endfunction

  localparam recip_lut_t RECIP_LUT = build_recip();
  localparam dc_lut_t    DC_LUT    = build_dc();

endpackage

`default_nettype wire

// ----- rtl/jpeg_quality_quant_scaler_top.sv -----
// Top level of the JPEG quality quantizer scaler: four-stage pipeline.
// Depends on jqqs_pkg for the scale mapping and reciprocal tables.
//
// Usage:
//   in_*   : one base quantizer table entry per request (in_tdata[7:0]).
//   out_*  : one result per request, quantizer, SRAM word and DC reciprocal.
//   cfg_*  : 7-bit quality write, stored as its scale; always ready. Write only
//            while the pipeline is empty.
// Throughput is one request per cycle while out_tready is high; each of the
// four stages holds one request with a valid bit, set by the multiply, the
// divide-by-100 multiply, the clamp and the table lookup.
// When out_tready is low the last stage holds its result and the earlier
// stages keep filling bubbles, so input is still taken until all four stages
// are full. Nothing is lost or repeated across a stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets quality to 90.
`default_nettype none

module jpeg_quality_quant_scaler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] base_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] quant_value, [30:8] sram_word,
                                       // [41:31] dc_reciprocal, [47:42] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data    // quality
);

  logic [jqqs_pkg::ScaleW-1:0] scale_r;

  logic                        v1_r, v2_r, v3_r, v4_r;
  logic                        rdy1, rdy2, rdy3, rdy4;
  logic [jqqs_pkg::ProdW-1:0]  prod_r, prod_nxt;
  logic [27:0]                 mul_r, mul_nxt;
  logic                        sat_r;
  logic [jqqs_pkg::QuantW-1:0] q_r, q_nxt, q0;
  logic [jqqs_pkg::QuantW-1:0] quant_r;
  logic [jqqs_pkg::RecipW-1:0] recip_r;
  logic [jqqs_pkg::DcW-1:0]    dc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= jqqs_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= jqqs_pkg::scale_of(cfg_data);
    end
  end

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign prod_nxt = jqqs_pkg::ProdW'(in_tdata) * jqqs_pkg::ProdW'(scale_r)
                    + jqqs_pkg::ROUND_BIAS;
  assign mul_nxt  = 28'(prod_r[14:0]) * 28'(jqqs_pkg::DIV100_MULT);
  assign q0       = mul_r[26:19];

  always_comb begin
    if (sat_r) begin
      q_nxt = '1;
    end else if (q0 == '0) begin
      q_nxt = jqqs_pkg::QuantW'(1);
    end else begin
      q_nxt = q0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) prod_r <= prod_nxt;
    if (rdy2 && v1_r) begin
      mul_r <= mul_nxt;
      sat_r <= (prod_r >= jqqs_pkg::SAT_LIMIT);
    end
    if (rdy3 && v2_r) q_r <= q_nxt;
    if (rdy4 && v3_r) begin
      quant_r <= q_r;
      recip_r <= jqqs_pkg::RECIP_LUT[q_r];
      dc_r    <= jqqs_pkg::DC_LUT[q_r];
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {6'b0, dc_r, quant_r[7:1], recip_r, quant_r};

`ifndef ASSERT_OFF
  a_quant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] != 8'd0))
    else $error("quantizer of zero at output");

  a_sram_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[30:24] == out_tdata[7:1]))
    else $error("sram word half quantizer mismatch");

  a_dc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[41:31] >= 11'd4 && out_tdata[41:31] <= 11'd1024))
    else $error("dc reciprocal out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> (v3_r && $stable(q_r)))
    else $error("stalled clamp stage lost its request");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    scale_r <= jqqs_pkg::ScaleW'(5000))
    else $error("scale out of range");
`endif

endmodule

`default_nettype wire
